@@ sv/f32add_pkg.sv @@
// Shared types and constants for the single-precision adder.
package f32add_pkg;

    localparam logic [31:0] QNAN     = 32'hffc00000;
    localparam logic [31:0] PINF     = 32'h7f800000;
    localparam logic [31:0] NINF     = 32'hff800000;
    localparam int          GUARD    = 25;
    localparam int          WIDE_W   = 50;
    localparam logic [7:0]  FAR_LIM  = 8'd24;

    // special-case result selection carried down the pipe
    typedef enum logic [1:0] {
        SEL_CALC,
        SEL_FIXED,
        SEL_ZERO
    } sel_t;

endpackage

@@ sv/float32_adder_unit.sv @@
// Pipelined IEEE-754 single-precision adder, round to nearest even.
//
// Input words arrive on s_axis (tdata = operand_a in bits 31:0, operand_b in
// bits 63:32); each gives one sum word on m_axis (tdata = sum).
// Four register stages: classify/order, align and add/subtract,
// leading-one search and normalize shift, round and pack. An accepted word
// passes through the stage 1, 2 and 3 registers and sum_reg before it shows
// on m_axis. A new word is accepted every cycle unless a full pipe is stalled.
// Each stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so a stall on m_axis_tready backs up through
// the pipe without losing or repeating a word, and s_axis_tready drops
// only once all stages are full.
// Reset clears all valid bits; payload registers are not reset.
// NaN operands and opposite infinities give 0xffc00000, infinities pass,
// denormals are kept, exact cancellation gives +0.
module float32_adder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // sum
);

    localparam int W = f32add_pkg::WIDE_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || m_axis_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= s_axis_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: classify and order ----------------
    logic [31:0] a, b, ma, mb, big, sml;
    logic        nan_a, nan_b, inf_a, inf_b;
    f32add_pkg::sel_t sel_next;
    logic [31:0] fixed_next;
    logic [7:0]  eb, es;

    assign a  = s_axis_tdata[31:0];
    assign b  = s_axis_tdata[63:32];
    assign ma = {1'b0, a[30:0]};
    assign mb = {1'b0, b[30:0]};
    assign nan_a = ma > f32add_pkg::PINF;
    assign nan_b = mb > f32add_pkg::PINF;
    assign inf_a = ma == f32add_pkg::PINF;
    assign inf_b = mb == f32add_pkg::PINF;
    assign big   = (ma > mb) ? a : b;
    assign sml   = (ma > mb) ? b : a;
    assign eb = big[30:23];
    assign es = sml[30:23];

    always_comb
    begin
        sel_next   = f32add_pkg::SEL_FIXED;
        fixed_next = big;
        if (nan_a || nan_b)
            fixed_next = f32add_pkg::QNAN;
        else if (inf_a && inf_b && (a[31] ^ b[31]))
            fixed_next = f32add_pkg::QNAN;
        else if ((inf_a && !a[31]) || (inf_b && !b[31]))
            fixed_next = f32add_pkg::PINF;
        else if (inf_a || inf_b)
            fixed_next = f32add_pkg::NINF;
        else if (ma == 32'd0)
            fixed_next = b;
        else if (mb == 32'd0)
            fixed_next = a;
        else if ((eb - es) > f32add_pkg::FAR_LIM)
            fixed_next = big;
        else
            sel_next = f32add_pkg::SEL_CALC;
    end

    f32add_pkg::sel_t s1_sel_reg;
    logic [31:0] s1_fixed_reg;
    logic        s1_sign_reg, s1_sub_reg;
    logic [7:0]  s1_ebe_reg;
    logic [4:0]  s1_shift_reg;
    logic [23:0] s1_mb_reg, s1_ms_reg;

    logic [7:0] ebe, ese, shift8;
    assign ebe    = (eb != 8'd0) ? eb : 8'd1;
    assign ese    = (es != 8'd0) ? es : 8'd1;
    assign shift8 = ebe - ese;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_sel_reg   <= sel_next;
            s1_fixed_reg <= fixed_next;
            s1_sign_reg  <= big[31];
            s1_sub_reg   <= a[31] ^ b[31];
            s1_ebe_reg   <= ebe;
            s1_shift_reg <= shift8[4:0];
            s1_mb_reg    <= {(eb != 8'd0), big[22:0]};
            s1_ms_reg    <= {(es != 8'd0), sml[22:0]};
        end
    end

    // ---------------- stage 2: align and add ----------------
    logic [W-1:0] wb, ws, r_next;
    assign wb = {{(W-24-f32add_pkg::GUARD){1'b0}}, s1_mb_reg,
                 {f32add_pkg::GUARD{1'b0}}};
    assign ws = {{(W-24-f32add_pkg::GUARD){1'b0}}, s1_ms_reg,
                 {f32add_pkg::GUARD{1'b0}}} >> s1_shift_reg;
    assign r_next = s1_sub_reg ? (wb - ws) : (wb + ws);

    f32add_pkg::sel_t s2_sel_reg;
    logic [31:0]  s2_fixed_reg;
    logic         s2_sign_reg;
    logic [7:0]   s2_ebe_reg;
    logic [W-1:0] s2_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_sel_reg   <= (s1_sel_reg == f32add_pkg::SEL_CALC && r_next == '0)
                            ? f32add_pkg::SEL_ZERO : s1_sel_reg;
            s2_fixed_reg <= s1_fixed_reg;
            s2_sign_reg  <= s1_sign_reg;
            s2_ebe_reg   <= s1_ebe_reg;
            s2_r_reg     <= r_next;
        end
    end

    // ---------------- stage 3: leading one and normalize ----------------
    // r < 2^50; msb p in 0..49. eres = ebe + p - 48; e = max(eres,1);
    // shift sh = e - ebe + 25 in -23..26 (right when positive).
    logic [5:0]       p;
    logic signed [10:0] eres, e, sh;
    always_comb
    begin
        p = 6'd0;
        for (int i = 0; i < W; i++)
            if (s2_r_reg[i]) p = 6'(i);
    end
    assign eres = $signed({3'b0, s2_ebe_reg}) + $signed({5'b0, p}) - 11'sd48;
    assign e    = (eres >= 11'sd1) ? eres : 11'sd1;
    assign sh   = e - $signed({3'b0, s2_ebe_reg}) + 11'sd25;

    // aligned so the kept bits sit at [W+23:W] with 50 bits of shifted-out tail
    logic [2*W-1:0] ext, shifted;
    assign ext = {s2_r_reg, {W{1'b0}}};
    assign shifted = (sh > 11'sd0) ? (ext >> sh[5:0]) : (ext << (-sh));

    f32add_pkg::sel_t s3_sel_reg;
    logic [31:0]  s3_fixed_reg;
    logic         s3_sign_reg;
    logic [7:0]   s3_e_reg;
    logic [24:0]  s3_q_reg;
    logic         s3_half_reg, s3_sticky_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_sel_reg    <= s2_sel_reg;
            s3_fixed_reg  <= s2_fixed_reg;
            s3_sign_reg   <= s2_sign_reg;
            s3_e_reg      <= 8'(e - 11'sd1);
            s3_q_reg      <= shifted[W+24:W];
            s3_half_reg   <= shifted[W-1];
            s3_sticky_reg <= |shifted[W-2:0];
        end
    end

    // ---------------- stage 4: round and pack ----------------
    logic [32:0] bits;
    logic        rnd;
    logic [31:0] calc;
    assign rnd  = s3_half_reg && (s3_sticky_reg || s3_q_reg[0]);
    assign bits = {2'b0, s3_e_reg, 23'd0} + {8'd0, s3_q_reg} + 33'(rnd);
    assign calc = {s3_sign_reg,
                   (bits >= {1'b0, f32add_pkg::PINF}) ? f32add_pkg::PINF[30:0]
                                                      : bits[30:0]};

    logic [31:0] sum_reg;
    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            case (s3_sel_reg)
                f32add_pkg::SEL_CALC:  sum_reg <= calc;
                f32add_pkg::SEL_ZERO:  sum_reg <= 32'd0;
                default:               sum_reg <= s3_fixed_reg;
            endcase
        end
    end

    assign m_axis_tdata = sum_reg;

endmodule

@@ test/tb_float32_adder_unit.sv @@
// Testbench for the single-precision adder: directed table plus random words.
`timescale 1ns / 1ps

module tb_float32_adder_unit;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // operand_a, operand_b
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // sum

    localparam int N_RANDOM   = 1250;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        fixed;     // expected sum given in the row
        logic [31:0] sum;
    } vec_t;

    logic [31:0] sum_queue[$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          calm;          // no stalls near the end

    float32_adder_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int top_bit(logic [63:0] v);
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
                return i;
        end
        return -1;
    endfunction

    function automatic logic [31:0] round_pack(logic sgn, int ebase, logic [63:0] mag);
        int          p;
        int          e;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        p  = top_bit(mag);
        e  = ebase + p - (23 + f32add_pkg::GUARD);
        if (e < 1)
            e = 1;
        sh = e - ebase + f32add_pkg::GUARD;
        if (sh > 0)
        begin
            q    = mag >> sh;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q++;
        end
        else
            q = mag << (-sh);
        bits = (64'(e - 1) << 23) + q;
        if (bits >= 64'(f32add_pkg::PINF))
            bits = 64'(f32add_pkg::PINF);
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        int          ebe;
        int          ese;
        logic [63:0] wb;
        logic [63:0] ws;
        logic [63:0] r;
        if (a[30:0] > 31'h7f800000 || b[30:0] > 31'h7f800000)
            return f32add_pkg::QNAN;
        if (a[30:0] == 31'h7f800000 && b[30:0] == 31'h7f800000 && a[31] != b[31])
            return f32add_pkg::QNAN;
        if ((a[30:0] == 31'h7f800000 && !a[31]) || (b[30:0] == 31'h7f800000 && !b[31]))
            return f32add_pkg::PINF;
        if (a[30:0] == 31'h7f800000 || b[30:0] == 31'h7f800000)
            return f32add_pkg::NINF;
        if (a[30:0] == 0)
            return b;
        if (b[30:0] == 0)
            return a;
        if (a[30:0] > b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eb = big[30:23];
        es = sml[30:23];
        if (eb - es > f32add_pkg::FAR_LIM)
            return big;
        ebe = (eb != 0) ? int'(eb) : 1;
        ese = (es != 0) ? int'(es) : 1;
        wb = 64'({(eb != 0), big[22:0]}) << f32add_pkg::GUARD;
        ws = (64'({(es != 0), sml[22:0]}) << f32add_pkg::GUARD) >> (ebe - ese);
        r  = (a[31] == b[31]) ? wb + ws : wb - ws;
        if (r == 0)
            return 32'h0;
        return round_pack(big[31], ebe, r);
    endfunction

    // biased toward close exponents and special encodings
    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hff;
            1: v[30:23] = 8'h00;
            2: v[30:0]  = 31'h0;
            3: v[30:23] = 8'hfe;
            default: v[30:23] = 8'(120 + $urandom_range(0, 16));
        endcase
        return v;
    endfunction

    task automatic send_word(logic [31:0] a, logic [31:0] b, logic fixed, logic [31:0] sum);
        logic [31:0] want;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        want = fixed ? sum : float_sum(a, b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sum_queue.push_back(want);
        @(negedge clk);
    endtask

    // output side: random stalls and checking
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sum_queue.size() == 0)
            begin
                $error("unexpected sum word %h", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                if (m_axis_tdata !== sum_queue[0])
                begin
                    $error("sum: expected %h, actual %h", sum_queue[0], m_axis_tdata);
                    fail_cnt++;
                end
                void'(sum_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_float32_adder_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        vec_t table_rows[$];
        logic [31:0] a;
        logic [31:0] b;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        table_rows = '{
            '{32'h7fc00000, 32'h3f800000, 1, 32'hffc00000},  // NaN operand
            '{32'h3f800000, 32'hff800001, 1, 32'hffc00000},
            '{32'h7f800000, 32'hff800000, 1, 32'hffc00000},  // opposite infinities
            '{32'h7f800000, 32'h7f800000, 1, 32'h7f800000},
            '{32'hff800000, 32'h3f800000, 1, 32'hff800000},
            '{32'h00000000, 32'hbf800000, 1, 32'hbf800000},  // zero a returns b
            '{32'h80000000, 32'h00000000, 1, 32'h00000000},
            '{32'h40400000, 32'h80000000, 1, 32'h40400000},  // zero b returns a
            '{32'h3f800000, 32'hbf800000, 1, 32'h00000000},  // exact cancellation
            '{32'h7f7fffff, 32'h7f7fffff, 1, 32'h7f800000},  // overflow
            '{32'hff7fffff, 32'hff7fffff, 1, 32'hff800000},
            '{32'h4c000000, 32'h33800000, 1, 32'h4c000000},  // far apart
            '{32'h3f800000, 32'h3f800000, 1, 32'h40000000},
            '{32'h00000001, 32'h00000001, 0, 0},              // denormals
            '{32'h00800000, 32'h80000001, 0, 0},
            '{32'h807fffff, 32'h00000001, 0, 0},
            '{32'h3f800000, 32'h33800000, 0, 0},              // tie to even
            '{32'h3f800001, 32'h33800000, 0, 0},
            '{32'h3f800000, 32'hb3800001, 0, 0},
            '{32'h4b7fffff, 32'h3f000000, 0, 0},
            '{32'hffffffff, 32'h00000000, 0, 0},
            '{32'hc0000000, 32'h40000000, 0, 0}
        };
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (table_rows[i])
            send_word(table_rows[i].a, table_rows[i].b, table_rows[i].fixed, table_rows[i].sum);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                // hold off until the pipe drains
                s_axis_tvalid <= 1'b0;
                while (sum_queue.size() != 0)
                    @(negedge clk);
            end
            if (n == N_RANDOM - 150)
                calm = 1'b1;
            a = rand_float();
            b = rand_float();
            if ($urandom_range(0, 3) == 0)
                b = {~a[31], a[30:23], a[22:0] ^ 23'($urandom_range(0, 3))};
            send_word(a, b, 1'b0, 32'h0);
        end
        s_axis_tvalid <= 1'b0;
        while (sum_queue.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_cnt == 0)
            $display("tb_float32_adder_unit OK");
        else
            $display("tb_float32_adder_unit NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
sv/f32add_pkg.sv
sv/float32_adder_unit.sv
test/tb_float32_adder_unit.sv
